// ===== sv/pss_pkg.sv =====
// Shared constants, types and codes of the point store nearest search block.
`timescale 1ns / 1ps

package pss_pkg;

   // Table size and derived widths
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 16;
   localparam int DX_W       = COORD_W + 1;
   localparam int SQ_W       = 2 * DX_W;
   localparam int DIST_W     = SQ_W + 1;
   localparam int MAG_W      = COORD_W + IDX_W;
   localparam int SUM_W      = MAG_W + 1;
   localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

   // Port field widths
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int OUT_IDX_W  = 6;
   localparam int OUT_CNT_W  = 7;

   // Command codes; the unused code runs as a query
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Sequencer to distance unit
   typedef struct packed {
      logic             start;
      logic             load;
      logic [IDX_W-1:0] idx;
   } scan_ctrl_type;

   // Distance unit to sequencer
   typedef struct packed {
      logic             busy;
      logic [IDX_W-1:0] idx;
      coord_type        x;
      coord_type        y;
   } best_type;

   // Divider to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/pss_if.sv =====
// Request and response channel interfaces of the point store nearest search block.
`timescale 1ns / 1ps

interface pss_req_if import pss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   coord_type        point_x;
   coord_type        point_y;

   modport source (output valid, command, point_x, point_y, input ready);
   modport sink   (input valid, command, point_x, point_y, output ready);
endinterface

interface pss_rsp_if import pss_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [OUT_IDX_W-1:0] nearest_index;
   coord_type            nearest_x;
   coord_type            nearest_y;
   coord_type            centroid_x_out;
   coord_type            centroid_y_out;
   logic [OUT_CNT_W-1:0] point_count;

   modport source (output valid, status, nearest_index, nearest_x, nearest_y,
                   centroid_x_out, centroid_y_out, point_count, input ready);
   modport sink   (input valid, status, nearest_index, nearest_x, nearest_y,
                   centroid_x_out, centroid_y_out, point_count, output ready);
endinterface

// ===== sv/pss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pss_dist_unit.sv =====
// Squared distance unit with running minimum over the scanned entries.
`timescale 1ns / 1ps

module pss_dist_unit import pss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  scan_ctrl_type ctrl,
   input  coord_type     point_x,
   input  coord_type     point_y,
   input  coord_type     rd_x,
   input  coord_type     rd_y,
   output best_type      best
);

   logic signed [DX_W-1:0] dx;
   logic signed [DX_W-1:0] dy;
   logic [DIST_W-1:0]      sq_sum;

   // square stage
   logic             sq_valid_ff, sq_valid_in;
   logic [IDX_W-1:0] sq_idx_ff, sq_idx_in;
   coord_type        sq_x_ff, sq_x_in;
   coord_type        sq_y_ff, sq_y_in;
   logic [SQ_W-1:0]  dxx_ff, dxx_in;
   logic [SQ_W-1:0]  dyy_ff, dyy_in;

   // running best
   logic              have_ff, have_in;
   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   coord_type         best_x_ff, best_x_in;
   coord_type         best_y_ff, best_y_in;

   always_comb begin
      // squares of the coordinate differences, registered before the add
      dx          = DX_W'(rd_x) - DX_W'(point_x);
      dy          = DX_W'(rd_y) - DX_W'(point_y);
      dxx_in      = $unsigned(SQ_W'(dx * dx));
      dyy_in      = $unsigned(SQ_W'(dy * dy));
      sq_valid_in = ctrl.load;
      sq_idx_in   = ctrl.idx;
      sq_x_in     = rd_x;
      sq_y_in     = rd_y;

      // sum and compare; strict less keeps the first of equal distances
      sq_sum      = {1'b0, dxx_ff} + {1'b0, dyy_ff};
      have_in     = have_ff;
      best_d_in   = best_d_ff;
      best_idx_in = best_idx_ff;
      best_x_in   = best_x_ff;
      best_y_in   = best_y_ff;
      if (ctrl.start) begin
         have_in = 1'b0;
      end else if (sq_valid_ff && (!have_ff || sq_sum < best_d_ff)) begin
         have_in     = 1'b1;
         best_d_in   = sq_sum;
         best_idx_in = sq_idx_ff;
         best_x_in   = sq_x_ff;
         best_y_in   = sq_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         have_ff     <= have_in;
      end
      sq_idx_ff   <= sq_idx_in;
      sq_x_ff     <= sq_x_in;
      sq_y_ff     <= sq_y_in;
      dxx_ff      <= dxx_in;
      dyy_ff      <= dyy_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
   end

   assign best.busy = sq_valid_ff;
   assign best.idx  = best_idx_ff;
   assign best.x    = best_x_ff;
   assign best.y    = best_y_ff;

endmodule

// ===== sv/pss_divider.sv =====
// Two-lane restoring divider: signed coordinate sums over the point count.
`timescale 1ns / 1ps

module pss_divider import pss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sum_type          dividend_x,
   input  sum_type          dividend_y,
   input  logic [CNT_W-1:0] divisor,
   output div_stat_type     stat,
   output coord_type        quot_x,
   output coord_type        quot_y
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] iter_ff, iter_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [CNT_W-1:0]     rem_ff [2];
   logic [CNT_W-1:0]     rem_in [2];
   logic [MAG_W-1:0]     q_ff [2];
   logic [MAG_W-1:0]     q_in [2];
   logic                 neg_ff [2];
   logic                 neg_in [2];
   sum_type              dvd [2];
   logic [CNT_W:0]       trial [2];
   logic [MAG_W-1:0]     qs [2];

   assign dvd[0] = dividend_x;
   assign dvd[1] = dividend_y;

   // one quotient bit per lane each cycle, magnitudes first, sign at the end
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      div_in  = div_ff;
      for (int l = 0; l < 2; l++) begin
         rem_in[l] = rem_ff[l];
         q_in[l]   = q_ff[l];
         neg_in[l] = neg_ff[l];
         trial[l]  = {rem_ff[l], q_ff[l][MAG_W-1]};
         qs[l]     = neg_ff[l] ? -q_ff[l] : q_ff[l];
      end
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         div_in  = divisor;
         for (int l = 0; l < 2; l++) begin
            neg_in[l] = dvd[l][SUM_W-1];
            q_in[l]   = MAG_W'(dvd[l][SUM_W-1] ? -dvd[l] : dvd[l]);
            rem_in[l] = '0;
         end
      end else if (busy_ff) begin
         for (int l = 0; l < 2; l++) begin
            if (trial[l] >= {1'b0, div_ff}) begin
               rem_in[l] = CNT_W'(trial[l] - {1'b0, div_ff});
               q_in[l]   = {q_ff[l][MAG_W-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][CNT_W-1:0];
               q_in[l]   = {q_ff[l][MAG_W-2:0], 1'b0};
            end
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == DIV_CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      div_ff <= div_in;
      for (int l = 0; l < 2; l++) begin
         rem_ff[l] <= rem_in[l];
         q_ff[l]   <= q_in[l];
         neg_ff[l] <= neg_in[l];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot_x    = COORD_W'(qs[0]);
   assign quot_y    = COORD_W'(qs[1]);

endmodule

// ===== sv/point_store_nearest_search_core.sv =====
// Top level: command sequencer, point table, running sums and centroid.
//
// Point store with nearest-point search. One request word carries a command
// (add, move nearest here, query nearest) and a Q12.4 point; every request
// gives exactly one response word with status, the nearest stored point and
// its index as found before the write, the centroid and the point count.
// Both channels use valid/ready; a word moves when both are high.
// The table sits in one RAM, read one entry per cycle by the sequencer and
// fed through the shared squared-distance unit. With stored points the
// response is loaded after the scan and the pipeline drain; an empty table
// skips both. An add that stores a point also runs the two-lane bit-serial
// division of the running sums by the count. An add to a full table is
// rejected. One request is in work at a time.
// The response sits in an output register, so the next request is taken
// while it waits; that request finishes its work and then holds until the
// receiver takes the earlier word. Reset empties the table and zeroes the
// centroid; no clearing pass is needed, as only written entries are read.
`timescale 1ns / 1ps

module point_store_nearest_search_core import pss_pkg::*; (
   input logic clock,
   input logic reset,
   pss_req_if.sink   req_ch,
   pss_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;

   // latched request
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   coord_type        px_ff, px_in;
   coord_type        py_ff, py_in;

   // scan control
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // block state
   logic [CNT_W-1:0] count_ff, count_in;
   sum_type          sum_x_ff, sum_x_in;
   sum_type          sum_y_ff, sum_y_in;
   coord_type        cent_x_ff, cent_x_in;
   coord_type        cent_y_ff, cent_y_in;

   // result of the current request
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic [IDX_W-1:0]    near_idx_ff, near_idx_in;
   coord_type           near_x_ff, near_x_in;
   coord_type           near_y_ff, near_y_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_stat_ff, rsp_stat_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   coord_type            rsp_nx_ff, rsp_nx_in;
   coord_type            rsp_ny_ff, rsp_ny_in;
   coord_type            rsp_cx_ff, rsp_cx_in;
   coord_type            rsp_cy_ff, rsp_cy_in;
   logic [OUT_CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // RAM ports
   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [2*COORD_W-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [2*COORD_W-1:0]   ram_rd_data;

   scan_ctrl_type scan_ctrl;
   best_type      best;
   logic          div_start;
   div_stat_type  div_stat;
   coord_type     quot_x;
   coord_type     quot_y;
   logic          accept;
   logic          have;

   pss_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pss_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (scan_ctrl),
      .point_x (px_ff),
      .point_y (py_ff),
      .rd_x    (ram_rd_data[2*COORD_W-1:COORD_W]),
      .rd_y    (ram_rd_data[COORD_W-1:0]),
      .best    (best)
   );

   pss_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (sum_x_in),
      .dividend_y (sum_y_in),
      .divisor    (count_in),
      .stat       (div_stat),
      .quot_x     (quot_x),
      .quot_y     (quot_y)
   );

   assign accept = req_ch.valid && req_ch.ready;
   assign have   = (count_ff != '0);

   // sequencer: next state, RAM and unit controls, register next values
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      scan_cnt_in  = scan_cnt_ff;
      count_in     = count_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      cent_x_in    = cent_x_ff;
      cent_y_in    = cent_y_ff;
      stat_in      = stat_ff;
      near_idx_in  = near_idx_ff;
      near_x_in    = near_x_ff;
      near_y_in    = near_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_nx_in    = rsp_nx_ff;
      rsp_ny_in    = rsp_ny_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      req_ch.ready    = (state_ff == ST_IDLE);
      scan_ctrl.start = 1'b0;
      scan_ctrl.load  = rd_valid_ff;
      scan_ctrl.idx   = rd_idx_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = scan_cnt_ff[IDX_W-1:0];
      ram_wr_en       = 1'b0;
      ram_wr_addr     = count_ff[IDX_W-1:0];
      ram_wr_data     = {px_ff, py_ff};
      div_start       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_ch.command;
               px_in       = req_ch.point_x;
               py_in       = req_ch.point_y;
               scan_cnt_in = '0;
               if (have) begin
                  scan_ctrl.start = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_SCAN: begin
            // one table read per cycle
            if (scan_cnt_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !best.busy) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            stat_in     = STAT_OK;
            near_idx_in = have ? best.idx : '0;
            near_x_in   = have ? best.x : '0;
            near_y_in   = have ? best.y : '0;
            state_in    = ST_FINISH;
            case (cmd_ff)
               CMD_ADD: begin
                  if (count_ff >= CNT_W'(MAX_POINTS)) begin
                     stat_in = STAT_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + 1'b1;
                     sum_x_in  = sum_x_ff + SUM_W'(px_ff);
                     sum_y_in  = sum_y_ff + SUM_W'(py_ff);
                     div_start = 1'b1;
                     state_in  = ST_DIVIDE;
                  end
               end
               CMD_MOVE: begin
                  if (!have) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = best.idx;
                     sum_x_in    = sum_x_ff + SUM_W'(px_ff) - SUM_W'(best.x);
                     sum_y_in    = sum_y_ff + SUM_W'(py_ff) - SUM_W'(best.y);
                  end
               end
               default: begin
                  // query, and the unused code likewise
                  if (!have) begin
                     stat_in = STAT_EMPTY;
                  end
               end
            endcase
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               cent_x_in = quot_x;
               cent_y_in = quot_y;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // load the response register once the previous word is gone
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_idx_in   = OUT_IDX_W'(near_idx_ff);
               rsp_nx_in    = near_x_ff;
               rsp_ny_in    = near_y_ff;
               rsp_cx_in    = cent_x_ff;
               rsp_cy_in    = cent_y_ff;
               rsp_cnt_in   = OUT_CNT_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_valid_in = ram_rd_en;
      rd_idx_in   = ram_rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         cent_x_ff    <= '0;
         cent_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         count_ff     <= count_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         cent_x_ff    <= cent_x_in;
         cent_y_ff    <= cent_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      stat_ff     <= stat_in;
      near_idx_ff <= near_idx_in;
      near_x_ff   <= near_x_in;
      near_y_ff   <= near_y_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_nx_ff   <= rsp_nx_in;
      rsp_ny_ff   <= rsp_ny_in;
      rsp_cx_ff   <= rsp_cx_in;
      rsp_cy_ff   <= rsp_cy_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // response channel
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_stat_ff;
   assign rsp_ch.nearest_index  = rsp_idx_ff;
   assign rsp_ch.nearest_x      = rsp_nx_ff;
   assign rsp_ch.nearest_y      = rsp_ny_ff;
   assign rsp_ch.centroid_x_out = rsp_cx_ff;
   assign rsp_ch.centroid_y_out = rsp_cy_ff;
   assign rsp_ch.point_count    = rsp_cnt_ff;

   // table never holds more than its size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above table size");

   // count moves only by one, out of the update step
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         ($past(state_ff) == ST_UPDATE && count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("point count changed outside an add");

   // divider runs only while the sequencer waits on it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIVIDE)
      else $error("divider busy outside the divide step");

   // an accepted request closes the input until its work is done
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("request taken while another is in work");

endmodule
